// ===== design/kvvp_pkg.sv =====
// ----------------------------------------------------------------------------
// kvvp_pkg
// shared types, constants and the fraction power table of the victim planner
// ----------------------------------------------------------------------------
package kvvp_pkg;

	localparam int MAX_CANDIDATES      = 32;
	localparam int FRACTION_TABLE_BITS = 8;
	localparam int TAB_SIZE            = 1 << FRACTION_TABLE_BITS;
	localparam int IDX_W               = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNT_W               = $clog2(MAX_CANDIDATES + 1);
	localparam int RATE_W              = 23;
	localparam int TIME_W              = 52;
	localparam int PROB_W              = 17;
	localparam int REC_W               = 37;
	localparam int RCMP_W              = 53;
	localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(4294967);
	localparam logic [RCMP_W-1:0] RCMP_MAX = {RCMP_W{1'b1}};

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_PLAN = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [31:0]       cand_id;
		logic [31:0]       cand_tokens;
		logic [TIME_W-1:0] cand_last_used;
		logic [31:0]       cap_budget;
		logic [31:0]       need_est;
		logic [TIME_W-1:0] now_time;
	} req_t;

	typedef struct packed {
		logic              victim_valid;
		logic [31:0]       victim_id;
		logic [31:0]       victim_tokens;
		logic              last;
		logic [31:0]       shortfall;
		logic [REC_W-1:0]  freed_sum;
		logic [RCMP_W-1:0] expected_recompute;
		logic              load_overflow;
	} res_t;

	typedef struct packed {
		logic             load;
		logic             plan_init;
		logic             p_rd;
		logic             p_mul;
		logic             p_hi;
		logic             p_wr;
		logic             s_init;
		logic             s_rd;
		logic             s_cmp;
		logic             pick;
		logic             acc;
		logic             flush;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic met;
		logic found;
	} stat_t;

	typedef logic [TAB_SIZE-1:0][PROB_W-1:0] frac_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int n = 0; n < 32; n++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic frac_tab_t build_table();
		logic [10:0][63:0] c;
		logic [63:0] r;
		logic [63:0] x;
		frac_tab_t t;
		c[0] = 64'd1 << 31;
		for (int k = 1; k <= 10; k++) c[k] = isqrt64(c[k-1] << 32);
		for (int i = 0; i < TAB_SIZE; i++) begin
			x = 64'(i) << (10 - FRACTION_TABLE_BITS);
			r = 64'd1 << 32;
			for (int k = 1; k <= 10; k++)
				if (x[10-k]) r = (r * c[k]) >> 32;
			t[i] = PROB_W'((r + 64'd32768) >> 16);
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_table();

endpackage

// ===== design/kv_cache_victim_planner_unit.sv =====
// ----------------------------------------------------------------------------
// kv_cache_victim_planner_unit
// greedy least-likely-reuse eviction planner with overshoot tiebreak
// ----------------------------------------------------------------------------
// a load item is taken while idle and busy stays low. a plan item raises
// busy; it first sweeps all 32 slots through the probability unit (read,
// multiply, high part and write for each slot), then each victim costs a
// check, a scan setup, one scan of all slots (read and compare for each
// slot), a scan end, a pick and an accumulate; busy stays high until the
// flush, also when the store runs dry before the shortfall is covered.
// results come out as one-cycle strobes on res_valid and cannot be held
// off; the final item of a plan has last set and arrives as busy falls.
module kv_cache_victim_planner_unit
	import kvvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_data,
	output logic              res_valid,
	output res_t              res
);

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	kvvp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.busy     (busy),
		.cmd      (cmd)
	);

	kvvp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.res_valid (res_valid),
		.res       (res)
	);

`ifndef SYNTH
	// the final item closes the plan
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> !busy)
		else $error("last item while plan still running");

	// intermediate items only while the plan runs
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> busy)
		else $error("non-final item outside a plan");

	// an empty result is always the only one of its plan
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.victim_valid |-> res.last)
		else $error("empty item not marked last");
`endif

endmodule

// ===== design/kvvp_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvvp_ctrl
// sequencer for probability sweep, victim scans and result flush
// ----------------------------------------------------------------------------
module kvvp_ctrl
	import kvvp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  req_type,
	input  stat_t stat,
	output logic  busy,
	output cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_P_RD  = 4'd1;
	localparam logic [3:0] ST_P_MUL = 4'd2;
	localparam logic [3:0] ST_P_HI  = 4'd3;
	localparam logic [3:0] ST_P_WR  = 4'd4;
	localparam logic [3:0] ST_CHECK = 4'd5;
	localparam logic [3:0] ST_S_INI = 4'd6;
	localparam logic [3:0] ST_S_RD  = 4'd7;
	localparam logic [3:0] ST_S_CMP = 4'd8;
	localparam logic [3:0] ST_S_END = 4'd9;
	localparam logic [3:0] ST_PICK  = 4'd10;
	localparam logic [3:0] ST_ACC   = 4'd11;
	localparam logic [3:0] ST_FLUSH = 4'd12;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CANDIDATES - 1);

	logic [3:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load      = accept && (req_type == REQ_LOAD);
				cmd.plan_init = accept && (req_type == REQ_PLAN);
				if (cmd.plan_init) begin
					state_d = ST_P_RD;
					idx_d   = '0;
				end
			end
			ST_P_RD: begin
				cmd.p_rd = 1'b1;
				state_d  = ST_P_MUL;
			end
			ST_P_MUL: begin
				cmd.p_mul = 1'b1;
				state_d   = ST_P_HI;
			end
			ST_P_HI: begin
				cmd.p_hi = 1'b1;
				state_d  = ST_P_WR;
			end
			ST_P_WR: begin
				cmd.p_wr = 1'b1;
				if (idx_q == IDX_LAST) begin
					state_d = ST_CHECK;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_P_RD;
				end
			end
			ST_CHECK: begin
				state_d = stat.met ? ST_FLUSH : ST_S_INI;
			end
			ST_S_INI: begin
				cmd.s_init = 1'b1;
				idx_d      = '0;
				state_d    = ST_S_RD;
			end
			ST_S_RD: begin
				cmd.s_rd = 1'b1;
				state_d  = ST_S_CMP;
			end
			ST_S_CMP: begin
				cmd.s_cmp = 1'b1;
				if (idx_q == IDX_LAST) begin
					state_d = ST_S_END;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_S_RD;
				end
			end
			ST_S_END: begin
				state_d = stat.found ? ST_PICK : ST_FLUSH;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_CHECK;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ===== design/kvvp_dpath.sv =====
// ----------------------------------------------------------------------------
// kvvp_dpath
// candidate store, reuse probability unit, victim compare and sums
// ----------------------------------------------------------------------------
module kvvp_dpath
	import kvvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  req_t              req,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_data,
	output stat_t             stat,
	output logic              res_valid,
	output res_t              res
);

	logic [31:0]       mem_id [MAX_CANDIDATES];
	logic [31:0]       mem_tok[MAX_CANDIDATES];
	logic [TIME_W-1:0] mem_lu [MAX_CANDIDATES];
	logic [PROB_W-1:0] mem_p  [MAX_CANDIDATES];
	logic [MAX_CANDIDATES-1:0] valid_q;

	logic [RATE_W-1:0] rate_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [31:0]       deficit_q;
	logic [TIME_W-1:0] now_q;
	logic [REC_W-1:0]  rec_q;
	logic [RCMP_W-1:0] rcmp_q;

	// probability unit
	logic [TIME_W-1:0]        lu_rd_q;
	logic [TIME_W-1:0]        age_q;
	logic [31+RATE_W:0]       lo_q;
	logic                     big_q;
	logic [4:0]               sh_q;
	logic [FRACTION_TABLE_BITS-1:0] fidx_q;
	logic [TIME_W-1:0]        age;
	logic [TIME_W-33+RATE_W:0] hi_prod;
	logic [TIME_W-31+RATE_W:0] ipart;

	// scan
	logic [31:0]       s_tok_q, s_id_q;
	logic [PROB_W-1:0] s_p_q;
	logic              s_v_q;
	logic [IDX_W-1:0]  s_idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [PROB_W-1:0] best_p_q;
	logic [31:0]       best_over_q, best_tok_q, best_id_q;
	logic [31:0]       remaining, over;
	logic [PROB_W+31:0] prod_q;
	logic [RCMP_W:0]   rcmp_sum;
	logic [REC_W-1:0]  rec_new;
	logic [RCMP_W-1:0] rcmp_new;

	// pending result
	logic              pend_v_q;
	logic [31:0]       pend_id_q, pend_tok_q;
	logic [REC_W-1:0]  pend_rec_q;
	logic [RCMP_W-1:0] pend_rcmp_q;

	assign age       = (now_q > lu_rd_q) ? (now_q - lu_rd_q) : '0;
	assign hi_prod   = age_q[TIME_W-1:32] * rate_q;
	assign ipart     = (TIME_W-30+RATE_W)'(hi_prod) +
		(TIME_W-30+RATE_W)'(lo_q[31+RATE_W:32]);
	assign remaining = deficit_q - rec_q[31:0];
	assign over      = (s_tok_q > remaining) ? (s_tok_q - remaining) : 32'd0;
	assign rec_new   = rec_q + REC_W'(best_tok_q);
	assign rcmp_sum  = (RCMP_W+1)'(rcmp_q) + (RCMP_W+1)'(prod_q);
	assign rcmp_new  = (rcmp_sum > (RCMP_W+1)'(RCMP_MAX)) ? RCMP_MAX : rcmp_sum[RCMP_W-1:0];

	assign stat.met   = ((RCMP_W)'(rec_q) >= RCMP_W'(deficit_q));
	assign stat.found = found_q;

	// store memories
	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < CNT_W'(MAX_CANDIDATES))) begin
			mem_id [count_q[IDX_W-1:0]] <= req.cand_id;
			mem_tok[count_q[IDX_W-1:0]] <= req.cand_tokens;
			mem_lu [count_q[IDX_W-1:0]] <= req.cand_last_used;
		end
		if (cmd.p_rd) lu_rd_q <= mem_lu[cmd.idx];
		if (cmd.p_wr) mem_p[cmd.idx] <= big_q ? '0 : (FRAC_TAB[fidx_q] >> sh_q);
		if (cmd.s_rd) begin
			s_tok_q <= mem_tok[cmd.idx];
			s_id_q  <= mem_id[cmd.idx];
			s_p_q   <= mem_p[cmd.idx];
			s_idx_q <= cmd.idx;
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (cmd.plan_init) begin
			deficit_q <= (req.need_est > req.cap_budget) ?
				(req.need_est - req.cap_budget) : 32'd0;
			now_q     <= req.now_time;
		end
		if (cmd.p_mul) begin
			age_q <= age;
			lo_q  <= age[31:0] * rate_q;
		end
		if (cmd.p_hi) begin
			big_q  <= (ipart >= (TIME_W-30+RATE_W)'(17));
			sh_q   <= ipart[4:0];
			fidx_q <= lo_q[31:32-FRACTION_TABLE_BITS];
		end
		if (cmd.s_cmp && s_v_q) begin
			if (!found_q || (s_p_q < best_p_q) ||
			    ((s_p_q == best_p_q) && (over < best_over_q))) begin
				best_idx_q  <= s_idx_q;
				best_p_q    <= s_p_q;
				best_over_q <= over;
				best_tok_q  <= s_tok_q;
				best_id_q   <= s_id_q;
			end
		end
		if (cmd.pick) prod_q <= best_p_q * best_tok_q;
		if (cmd.acc) begin
			pend_id_q   <= best_id_q;
			pend_tok_q  <= best_tok_q;
			pend_rec_q  <= rec_new;
			pend_rcmp_q <= rcmp_new;
		end
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rate_q   <= RATE_MAX;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			rec_q    <= '0;
			rcmp_q   <= '0;
			found_q  <= 1'b0;
			pend_v_q <= 1'b0;
			s_v_q    <= 1'b0;
		end else begin
			if (cfg_we) rate_q <= (cfg_data > RATE_MAX) ? RATE_MAX : cfg_data;
			if (cmd.load) begin
				if (count_q < CNT_W'(MAX_CANDIDATES)) begin
					valid_q[count_q[IDX_W-1:0]] <= 1'b1;
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.plan_init) begin
				rec_q    <= '0;
				rcmp_q   <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.s_init) found_q <= 1'b0;
			if (cmd.s_rd) s_v_q <= valid_q[cmd.idx];
			if (cmd.s_cmp && s_v_q) found_q <= 1'b1;
			if (cmd.pick) valid_q[best_idx_q] <= 1'b0;
			if (cmd.acc) begin
				rec_q    <= rec_new;
				rcmp_q   <= rcmp_new;
				pend_v_q <= 1'b1;
			end
			if (cmd.flush) begin
				valid_q <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= (cmd.acc && pend_v_q) || cmd.flush;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.acc && pend_v_q) || cmd.flush) begin
			res.victim_valid       <= pend_v_q;
			res.victim_id          <= pend_v_q ? pend_id_q : 32'd0;
			res.victim_tokens      <= pend_v_q ? pend_tok_q : 32'd0;
			res.last               <= cmd.flush;
			res.shortfall          <= deficit_q;
			res.freed_sum          <= pend_v_q ? pend_rec_q : rec_q;
			res.expected_recompute <= pend_v_q ? pend_rcmp_q : rcmp_q;
			res.load_overflow      <= ovf_q;
		end
	end

endmodule

// ===== bench/kv_cache_victim_planner_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kv_cache_victim_planner_unit_tb
// self-checking bench: loads and plans against a behavioral eviction predictor
// ----------------------------------------------------------------------------
// items are driven on the falling edge and taken when start is high and busy
// low; result strobes are sampled on the rising edge and compared field by
// field with a queue of predicted victims. a directed table comes first, then
// a zero-decay run, then random plan sequences with random decay settings.
module kv_cache_victim_planner_unit_tb;
	import kvvp_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	req_t              req;
	logic              cfg_we;
	logic [RATE_W-1:0] cfg_data;
	logic              res_valid;
	res_t              res;

	kv_cache_victim_planner_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .res_valid(res_valid), .res(res)
	);

	// predictor state
	logic [31:0]       cand_id_q   [MAX_CANDIDATES];
	logic [31:0]       cand_tok_q  [MAX_CANDIDATES];
	logic [TIME_W-1:0] cand_used_q [MAX_CANDIDATES];
	logic              cand_live   [MAX_CANDIDATES];
	int                cand_count;
	logic              dropped;
	logic [31:0]       decay;
	logic [31:0]       pow_frac [TAB_SIZE];

	res_t victim_queue[$];
	int   mismatches;
	int   plans_run, loads_run, victims_seen;

	// 2^-(i/256) table from successive square roots of one half
	function automatic logic [63:0] root_of(input logic [63:0] v);
		logic [63:0] lo, hi, mid;
		lo = 0;
		hi = 64'd1 << 32;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	task automatic make_pow_table();
		logic [63:0] roots [11];
		logic [63:0] acc;
		logic [9:0]  x;
		roots[0] = 64'd1 << 31;
		for (int k = 1; k <= 10; k++) roots[k] = root_of(roots[k-1] << 32);
		for (int i = 0; i < TAB_SIZE; i++) begin
			x = 10'(i << (10 - FRACTION_TABLE_BITS));
			acc = 64'd1 << 32;
			for (int k = 1; k <= 10; k++)
				if (x[10-k]) acc = (acc * roots[k]) >> 32;
			pow_frac[i] = 32'((acc + 64'd32768) >> 16);
		end
	endtask

	function automatic logic [31:0] reuse_odds(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] used);
		logic [63:0]  age;
		logic [127:0] prod;
		logic [95:0]  ipart;
		age = now > used ? 64'(now - used) : 64'd0;
		prod = 128'(age) * 128'(decay);
		ipart = prod[127:32];
		if (ipart >= 17) return 0;
		return pow_frac[prod[31:32-FRACTION_TABLE_BITS]] >> ipart[4:0];
	endfunction

	task automatic set_decay(input logic [RATE_W-1:0] v);
		decay = (v > RATE_MAX) ? 32'(RATE_MAX) : 32'(v);
	endtask

	// work out the victims of one accepted item
	task automatic predict_item(input req_t r);
		logic [31:0] deficit, remaining, p, over, best_p, best_over;
		logic [63:0] reclaimed, recompute;
		int best, n;
		bit found;
		res_t e;
		if (r.req_type == REQ_LOAD) begin
			loads_run++;
			if (cand_count < MAX_CANDIDATES) begin
				cand_id_q[cand_count]   = r.cand_id;
				cand_tok_q[cand_count]  = r.cand_tokens;
				cand_used_q[cand_count] = r.cand_last_used;
				cand_live[cand_count]   = 1'b1;
				cand_count++;
			end else
				dropped = 1'b1;
			return;
		end
		plans_run++;
		deficit = r.need_est > r.cap_budget ?
			r.need_est - r.cap_budget : 0;
		reclaimed = 0;
		recompute = 0;
		n = 0;
		while (reclaimed < 64'(deficit)) begin
			remaining = 32'(64'(deficit) - reclaimed);
			found = 0;
			best = 0;
			best_p = 0;
			best_over = 0;
			for (int i = 0; i < MAX_CANDIDATES; i++) begin
				if (!cand_live[i]) continue;
				p = reuse_odds(r.now_time, cand_used_q[i]);
				over = cand_tok_q[i] > remaining ? cand_tok_q[i] - remaining : 0;
				if (!found || p < best_p || (p == best_p && over < best_over)) begin
					found = 1;
					best = i;
					best_p = p;
					best_over = over;
				end
			end
			if (!found) break;
			reclaimed += cand_tok_q[best];
			recompute += 64'(best_p) * 64'(cand_tok_q[best]);
			if (recompute > 64'(RCMP_MAX)) recompute = 64'(RCMP_MAX);
			cand_live[best] = 1'b0;
			e = '0;
			e.victim_valid = 1'b1;
			e.victim_id = cand_id_q[best];
			e.victim_tokens = cand_tok_q[best];
			e.shortfall = deficit;
			e.freed_sum = REC_W'(reclaimed);
			e.expected_recompute = RCMP_W'(recompute);
			e.load_overflow = dropped;
			victim_queue.insert(victim_queue.size(), e);
			n++;
		end
		if (n == 0) begin
			e = '0;
			e.last = 1'b1;
			e.shortfall = deficit;
			e.load_overflow = dropped;
			victim_queue.insert(victim_queue.size(), e);
		end else
			victim_queue[$].last = 1'b1;
		for (int i = 0; i < MAX_CANDIDATES; i++) cand_live[i] = 1'b0;
		cand_count = 0;
		dropped = 1'b0;
	endtask

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid) begin
			victims_seen++;
			if (victim_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", res);
			end else begin
				want = victim_queue.pop_front();
				if (res !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, res);
				end
			end
		end
	end

	// directed rows: item plus an optional typed-in expectation
	typedef struct {
		req_t r;
		bit   typed;
		res_t want;
	} row_t;
	row_t rows[$];

	function automatic req_t load_of(input logic [31:0] id, input logic [31:0] tok,
			input logic [TIME_W-1:0] used);
		req_t r;
		r = '0;
		r.req_type = REQ_LOAD;
		r.cand_id = id;
		r.cand_tokens = tok;
		r.cand_last_used = used;
		return r;
	endfunction

	function automatic req_t plan_of(input logic [31:0] cap, input logic [31:0] proj,
			input logic [TIME_W-1:0] now);
		req_t r;
		r = '0;
		r.req_type = REQ_PLAN;
		r.cap_budget = cap;
		r.need_est = proj;
		r.now_time = now;
		return r;
	endfunction

	function automatic res_t empty_result(input logic [31:0] deficit, input logic ovf);
		res_t e;
		e = '0;
		e.last = 1'b1;
		e.shortfall = deficit;
		e.load_overflow = ovf;
		return e;
	endfunction

	task automatic add_row(input req_t r);
		row_t w;
		w.r = r;
		w.typed = 0;
		w.want = '0;
		rows.insert(rows.size(), w);
	endtask

	task automatic add_typed(input req_t r, input res_t e);
		row_t w;
		w.r = r;
		w.typed = 1;
		w.want = e;
		rows.insert(rows.size(), w);
	endtask

	// sender gap: mostly short, sometimes long
	task automatic sender_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		repeat (g) @(negedge clk);
	endtask

	// drive one item and hold it until it is taken
	task automatic send_item(input req_t r);
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_item(r);
		@(negedge clk);
		start <= 1'b0;
		req <= '0;
	endtask

	task automatic wait_idle();
		int spins;
		spins = 0;
		while ((victim_queue.size() != 0 || busy) && spins < 200000) begin
			@(posedge clk);
			spins++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_decay(input logic [RATE_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		set_decay(v);
	endtask

	function automatic logic [TIME_W-1:0] rand_time();
		case ($urandom_range(0, 3))
			0: return TIME_W'({$urandom, $urandom});
			1: return TIME_W'($urandom_range(0, 100000));
			2: return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3000));
			default: return TIME_W'($urandom);
		endcase
	endfunction

	// one random phase: mostly well-formed load runs followed by a plan
	task automatic random_sequence(output int sent);
		int nload;
		logic [TIME_W-1:0] base, now;
		logic [31:0] cap, tot;
		req_t r;
		sent = 0;
		nload = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 10);
		base = rand_time();
		tot = 0;
		for (int i = 0; i < nload; i++) begin
			r = load_of($urandom,
				($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 4000),
				($urandom_range(0, 4) == 0) ? rand_time() :
				base - TIME_W'($urandom_range(0, 5000)));
			if ($urandom_range(0, 6) == 0)
				r.cand_tokens = (i > 0) ? rows.size() : 32'd500;
			tot += r.cand_tokens;
			send_item(r);
			sender_gap();
			sent++;
		end
		now = ($urandom_range(0, 5) == 0) ? rand_time() :
			base + TIME_W'($urandom_range(0, 3000));
		cap = $urandom;
		case ($urandom_range(0, 4))
			0: r = plan_of(cap, $urandom, now);
			1: r = plan_of(32'd0, 32'hffff_ffff, now);
			2: r = plan_of(cap, cap, now);
			default: r = plan_of(32'd1000, 32'd1000 + $urandom_range(1, tot + 100), now);
		endcase
		send_item(r);
		sender_gap();
		sent++;
	endtask

	initial begin
		res_t rec_one;
		int sent, total;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		plans_run = 0;
		loads_run = 0;
		victims_seen = 0;
		cand_count = 0;
		dropped = 1'b0;
		for (int i = 0; i < MAX_CANDIDATES; i++) cand_live[i] = 1'b0;
		make_pow_table();
		set_decay(RATE_MAX);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty store, zero deficit, extremes, ties, overflow
		add_typed(plan_of(32'd0, 32'd0, '0), empty_result(32'd0, 1'b0));
		add_typed(plan_of(32'd0, 32'hffff_ffff, {TIME_W{1'b1}}),
			empty_result(32'hffff_ffff, 1'b0));
		add_row(load_of(32'hffff_ffff, 32'hffff_ffff, {TIME_W{1'b1}}));
		add_row(load_of(32'h0, 32'd0, '0));
		add_row(load_of(32'h1234_5678, 32'd100, TIME_W'(1000)));
		add_row(load_of(32'h1234_5679, 32'd100, TIME_W'(1000)));
		add_row(plan_of(32'd0, 32'hffff_ffff, TIME_W'(500)));
		// tie on probability broken by overshoot, then by load order
		add_row(load_of(32'd1, 32'd300, TIME_W'(50)));
		add_row(load_of(32'd2, 32'd120, TIME_W'(50)));
		add_row(load_of(32'd3, 32'd120, TIME_W'(50)));
		add_row(plan_of(32'd100, 32'd200, TIME_W'(2000)));
		// capacity above projection gives no victim
		add_row(load_of(32'd9, 32'd5, TIME_W'(1)));
		add_typed(plan_of(32'hffff_ffff, 32'd7, TIME_W'(3)), empty_result(32'd0, 1'b0));
		// fill past the store to set the overflow flag
		for (int i = 0; i < MAX_CANDIDATES + 2; i++)
			add_row(load_of(32'(i + 100), 32'(i * 37 + 1), TIME_W'(i * 777)));
		add_row(plan_of(32'd0, 32'd1, TIME_W'(40000)));

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				send_item(rows[i].r);
				rec_one = victim_queue[$];
				if (rec_one !== rows[i].want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: expected %p predicted %p", i,
							rows[i].want, rec_one);
				end
			end else
				send_item(rows[i].r);
			sender_gap();
		end
		// pause until the block has drained everything
		wait_idle();

		// zero decay: every probability is one, big tokens give the largest sums
		write_decay('0);
		for (int i = 0; i < 32; i++)
			send_item(load_of(32'(i), 32'hffff_fff0 - 32'(i), TIME_W'(i)));
		send_item(plan_of(32'd0, 32'hffff_ffff, {TIME_W{1'b1}}));
		wait_idle();
		write_decay({RATE_W{1'b1}});
		rows.delete();

		total = 0;
		while (total < 275) begin
			if ($urandom_range(0, 5) == 0) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0: write_decay('0);
					1: write_decay(RATE_MAX);
					2: write_decay({RATE_W{1'b1}});
					default: write_decay(RATE_W'($urandom));
				endcase
			end
			random_sequence(sent);
			total += sent;
		end
		wait_idle();
		$display("covered %0d loads and %0d plans, %0d results checked",
			loads_run, plans_run, victims_seen);
		$display("decay settings included zero, the maximum and saturating writes");
		if (mismatches == 0 && victim_queue.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// guard against a hung block
	initial begin
		#60ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
design/kvvp_pkg.sv
design/kvvp_ctrl.sv
design/kvvp_dpath.sv
design/kv_cache_victim_planner_unit.sv
bench/kv_cache_victim_planner_unit_tb.sv
